FILE: design/mtep_pkg.sv
// Package for the MIDI track event parser: result kinds, parse phases, queue types.
// No dependencies.
package mtep_pkg;

   localparam logic [1:0] KIND_VOICE  = 2'd0;
   localparam logic [1:0] KIND_TEMPO  = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   localparam logic [1:0] CSR_CHUNK_LENGTH = 2'd0;
   localparam logic [1:0] CSR_SRC_TPQ      = 2'd1;
   localparam logic [1:0] CSR_EVENT_CAP    = 2'd2;

   localparam logic [7:0] ST_VOICE_LO = 8'h80;
   localparam logic [7:0] ST_VOICE_HI = 8'hEF;
   localparam logic [7:0] ST_SYSEX    = 8'hF0;
   localparam logic [7:0] ST_ESCAPE   = 8'hF7;
   localparam logic [7:0] ST_META     = 8'hFF;
   localparam logic [7:0] META_TEMPO  = 8'h51;
   localparam logic [7:0] ONE_DATA_MASK = 8'hE0;
   localparam logic [7:0] ONE_DATA_VAL  = 8'hC0;
   localparam logic [25:0] US_PER_MINUTE = 26'd60000000;
   localparam logic [6:0]  TARGET_TPQ    = 7'd96;

   typedef enum logic [9:0] {
      PH_DELTA     = 10'b00_0000_0001,
      PH_DELTA_MORE= 10'b00_0000_0010,
      PH_STATUS    = 10'b00_0000_0100,
      PH_META_TYPE = 10'b00_0000_1000,
      PH_META_LEN  = 10'b00_0001_0000,
      PH_TEMPO     = 10'b00_0010_0000,
      PH_SYSEX_LEN = 10'b00_0100_0000,
      PH_SKIP      = 10'b00_1000_0000,
      PH_DATA1     = 10'b01_0000_0000,
      PH_DATA2     = 10'b10_0000_0000
   } phase_type;

   // command handed from the front parser to the back end
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] ticks;      // absolute file ticks (voice)
      logic [23:0] tempo_us;   // us per quarter (tempo)
      logic [7:0]  status;
      logic [7:0]  data1;
      logic [7:0]  data2;
      logic [12:0] count;
      logic        last;
   } cmd_type;

endpackage

FILE: design/midi_track_event_parser.sv
// MIDI track event parser top level: front parser, command queue, divider back end.
// Depends on mtep_pkg, mtep_front, mtep_queue, mtep_back.
// Results: a voice result comes from a 39-step restoring divide of ticks*96 by the
// file ppqn, a tempo result from a 26-step divide; a finish result skips the divider.
// Throughput: one byte per cycle into the front when not stalled; divider limits results.
// Reset: synchronous, active high; clears parse state and control, registers to reset values.
module midi_track_event_parser #(
   parameter int MAX_EVENTS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [27:0] rsp_step,
   output logic [7:0]  rsp_sub_tick,
   output logic [7:0]  rsp_status_byte,
   output logic [7:0]  rsp_first_data,
   output logic [7:0]  rsp_second_data,
   output logic [15:0] rsp_tempo_bpm,
   output logic [12:0] rsp_events_in_chunk,
   output logic        rsp_last
);

   logic [31:0] chunk_ff;
   logic [15:0] ppqn_ff;
   logic [12:0] cap_ff;
   logic        restart;

   assign restart = csr_write_enable && csr_index == mtep_pkg::CSR_CHUNK_LENGTH;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= '0;
         ppqn_ff  <= 16'd96;
         cap_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            mtep_pkg::CSR_CHUNK_LENGTH: chunk_ff <= csr_write_data;
            mtep_pkg::CSR_SRC_TPQ:      ppqn_ff  <= csr_write_data[15:0];
            mtep_pkg::CSR_EVENT_CAP:    cap_ff   <= csr_write_data[12:0];
            default: ;
         endcase
      end
   end

   logic f_v, f_r, q_v, q_r;
   mtep_pkg::cmd_type f_c, q_c;

   // front parser: accepts bytes, emits commands
   mtep_front #(.MAX_EVENTS(MAX_EVENTS)) u_front (
      .clock, .reset, .restart,
      .chunk_length(chunk_ff), .event_capacity(cap_ff),
      .byte_valid(req_valid), .byte_ready(req_ready), .data_byte(req_data_byte),
      .cmd_valid(f_v), .cmd(f_c), .cmd_ready(f_r)
   );

   // short queue decouples parser from divider
   mtep_queue u_queue (
      .clock, .reset,
      .wr_valid(f_v), .wr_ready(f_r), .wr_cmd(f_c),
      .rd_valid(q_v), .rd_ready(q_r), .rd_cmd(q_c)
   );

   // back end: scale and divide, hold result for the response channel
   mtep_back u_back (
      .clock, .reset, .src_tpq(ppqn_ff),
      .cmd_valid(q_v), .cmd_ready(q_r), .cmd(q_c),
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_step, .rsp_sub_tick,
      .rsp_status_byte, .rsp_first_data, .rsp_second_data, .rsp_tempo_bpm,
      .rsp_events_in_chunk, .rsp_last
   );

endmodule

FILE: design/mtep_front.sv
// Front parser: consumes track bytes, tracks parse state, issues commands.
// Depends on mtep_pkg.
module mtep_front #(
   parameter int MAX_EVENTS = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 restart,
   input  logic [31:0]          chunk_length,
   input  logic [12:0]          event_capacity,
   input  logic                 byte_valid,
   output logic                 byte_ready,
   input  logic [7:0]           data_byte,
   output logic                 cmd_valid,
   output mtep_pkg::cmd_type    cmd,
   input  logic                 cmd_ready
);

   mtep_pkg::phase_type phase_ff, phase_in;
   logic [31:0] consumed_ff, consumed_in;
   logic [31:0] ticks_ff, ticks_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] skip_ff, skip_in;
   logic [7:0]  run_ff, run_in;
   logic [7:0]  cur_ff, cur_in;
   logic [7:0]  meta_ff, meta_in;
   logic [7:0]  held_ff, held_in;
   logic [23:0] tempo_ff, tempo_in;
   logic [1:0]  tseen_ff, tseen_in;
   logic [12:0] evcnt_ff, evcnt_in;
   logic        done_ff, done_in;

   // second command of a byte waits here
   logic        pend_ff, pend_in;
   mtep_pkg::cmd_type pend_cmd_ff, pend_cmd_in;
   logic        out_v_ff, out_v_in;
   mtep_pkg::cmd_type out_cmd_ff, out_cmd_in;

   logic [13:0] cap_w;
   logic [13:0] maxev_w;
   logic        take;

   assign maxev_w = (MAX_EVENTS > 8191) ? 14'h1FFF : 14'(MAX_EVENTS);
   assign cap_w   = ({1'b0, event_capacity} < maxev_w) ? {1'b0, event_capacity} : maxev_w;

   assign byte_ready = !pend_ff && (!out_v_ff || cmd_ready);
   assign take       = byte_valid && byte_ready;
   assign cmd_valid  = out_v_ff;
   assign cmd        = out_cmd_ff;

   function automatic mtep_pkg::cmd_type mk(input logic [1:0] k);
      mtep_pkg::cmd_type c;
      c = '0;
      c.kind = k;
      return c;
   endfunction

   always_comb begin
      logic [7:0]  b;
      logic [7:0]  st;
      logic        n;
      logic        stop;
      logic        fin;
      mtep_pkg::cmd_type c0, c1;
      logic        h0, h1;
      logic [31:0] la;
      logic [23:0] ta;
      phase_in = phase_ff; consumed_in = consumed_ff; ticks_in = ticks_ff;
      len_in = len_ff; skip_in = skip_ff; run_in = run_ff; cur_in = cur_ff;
      meta_in = meta_ff; held_in = held_ff; tempo_in = tempo_ff; tseen_in = tseen_ff;
      evcnt_in = evcnt_ff; done_in = done_ff;
      pend_in = pend_ff; pend_cmd_in = pend_cmd_ff;
      out_v_in = out_v_ff; out_cmd_in = out_cmd_ff;
      b = data_byte; st = 8'h00; n = 1'b0; fin = 1'b0;
      c0 = '0; c1 = '0; h0 = 1'b0; h1 = 1'b0; la = '0; ta = '0;
      stop = 1'b0;

      if (out_v_ff && cmd_ready) begin
         out_v_in = pend_ff;
         out_cmd_in = pend_cmd_ff;
         pend_in = 1'b0;
      end

      if (take && !done_ff) begin
         if (phase_ff == mtep_pkg::PH_DELTA &&
             (consumed_ff >= chunk_length || {1'b0, evcnt_ff} >= cap_w)) begin
            fin = 1'b1;
         end else begin
            if (consumed_ff != 32'hFFFF_FFFF) consumed_in = consumed_ff + 32'd1;
            case (phase_ff)
               mtep_pkg::PH_DELTA, mtep_pkg::PH_DELTA_MORE: begin
                  la = (phase_ff == mtep_pkg::PH_DELTA) ? 32'd0 : len_ff;
                  la = {la[24:0], b[6:0]};
                  len_in = la;
                  if (b[7]) phase_in = mtep_pkg::PH_DELTA_MORE;
                  else begin
                     ticks_in = ticks_ff + la;
                     phase_in = mtep_pkg::PH_STATUS;
                  end
               end
               mtep_pkg::PH_STATUS: begin
                  n = !b[7];
                  st = n ? run_ff : b;
                  if (!n) run_in = b;
                  cur_in = st;
                  len_in = '0;
                  if (st == mtep_pkg::ST_META) begin
                     phase_in = mtep_pkg::PH_META_TYPE;
                     if (n) begin
                        meta_in = b; phase_in = mtep_pkg::PH_META_LEN;
                     end
                  end else if (st inside {mtep_pkg::ST_SYSEX, mtep_pkg::ST_ESCAPE}) begin
                     phase_in = mtep_pkg::PH_SYSEX_LEN;
                     if (n) begin
                        la = {25'd0, b[6:0]};
                        len_in = la;
                        if (!b[7]) begin
                           skip_in = la;
                           phase_in = (la != 0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
                        end
                     end
                  end else if (st inside {[mtep_pkg::ST_VOICE_LO : mtep_pkg::ST_VOICE_HI]}) begin
                     phase_in = mtep_pkg::PH_DATA1;
                     if (n) begin
                        held_in = b;
                        if ((st & mtep_pkg::ONE_DATA_MASK) == mtep_pkg::ONE_DATA_VAL) begin
                           h0 = 1'b1; c0 = mk(mtep_pkg::KIND_VOICE);
                           c0.ticks = ticks_ff; c0.status = st; c0.data1 = b;
                           evcnt_in = evcnt_ff + 13'd1;
                           phase_in = mtep_pkg::PH_DELTA;
                        end else phase_in = mtep_pkg::PH_DATA2;
                     end
                  end else begin
                     fin = 1'b1;
                  end
               end
               mtep_pkg::PH_META_TYPE: begin
                  meta_in = b; len_in = '0; phase_in = mtep_pkg::PH_META_LEN;
               end
               mtep_pkg::PH_META_LEN: begin
                  la = {len_ff[24:0], b[6:0]};
                  len_in = la;
                  if (!b[7]) begin
                     if (meta_ff == mtep_pkg::META_TEMPO && la == 32'd3) begin
                        tempo_in = '0; tseen_in = '0; phase_in = mtep_pkg::PH_TEMPO;
                     end else begin
                        skip_in = la;
                        phase_in = (la != 0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
                     end
                  end
               end
               mtep_pkg::PH_TEMPO: begin
                  ta = {tempo_ff[15:0], b};
                  tempo_in = ta;
                  tseen_in = tseen_ff + 2'd1;
                  if (tseen_ff == 2'd2) begin
                     tseen_in = '0;
                     phase_in = mtep_pkg::PH_DELTA;
                     if (ta != 0) begin
                        h0 = 1'b1; c0 = mk(mtep_pkg::KIND_TEMPO); c0.tempo_us = ta;
                     end
                  end
               end
               mtep_pkg::PH_SYSEX_LEN: begin
                  la = {len_ff[24:0], b[6:0]};
                  len_in = la;
                  if (!b[7]) begin
                     skip_in = la;
                     phase_in = (la != 0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
                  end
               end
               mtep_pkg::PH_SKIP: begin
                  la = (skip_ff != 0) ? skip_ff - 32'd1 : skip_ff;
                  skip_in = la;
                  if (la == 0) phase_in = mtep_pkg::PH_DELTA;
               end
               mtep_pkg::PH_DATA1: begin
                  held_in = b;
                  if ((cur_ff & mtep_pkg::ONE_DATA_MASK) == mtep_pkg::ONE_DATA_VAL) begin
                     h0 = 1'b1; c0 = mk(mtep_pkg::KIND_VOICE);
                     c0.ticks = ticks_ff; c0.status = cur_ff; c0.data1 = b;
                     evcnt_in = evcnt_ff + 13'd1;
                     phase_in = mtep_pkg::PH_DELTA;
                  end else phase_in = mtep_pkg::PH_DATA2;
               end
               mtep_pkg::PH_DATA2: begin
                  h0 = 1'b1; c0 = mk(mtep_pkg::KIND_VOICE);
                  c0.ticks = ticks_ff; c0.status = cur_ff; c0.data1 = held_ff; c0.data2 = b;
                  evcnt_in = evcnt_ff + 13'd1;
                  phase_in = mtep_pkg::PH_DELTA;
               end
               default: phase_in = mtep_pkg::PH_DELTA;
            endcase
            stop = !fin && phase_in == mtep_pkg::PH_DELTA &&
                   (consumed_in >= chunk_length || {1'b0, evcnt_in} >= cap_w);
            fin = fin || stop;
         end
         if (fin) begin
            done_in = 1'b1;
            if (h0) begin
               h1 = 1'b1; c1 = mk(mtep_pkg::KIND_FINISH); c1.count = evcnt_in;
            end else begin
               h0 = 1'b1; c0 = mk(mtep_pkg::KIND_FINISH); c0.count = evcnt_in;
            end
         end
         c0.last = !h1;
         c1.last = 1'b1;
         if (h0) begin
            out_v_in = 1'b1; out_cmd_in = c0;
            pend_in = h1; pend_cmd_in = c1;
         end
      end

      if (restart) begin
         phase_in = mtep_pkg::PH_DELTA; consumed_in = '0; ticks_in = '0; len_in = '0;
         skip_in = '0; run_in = '0; cur_in = '0; meta_in = '0; held_in = '0;
         tempo_in = '0; tseen_in = '0; evcnt_in = '0; done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mtep_pkg::PH_DELTA; consumed_ff <= '0; ticks_ff <= '0; len_ff <= '0;
         skip_ff <= '0; run_ff <= '0; cur_ff <= '0; meta_ff <= '0; held_ff <= '0;
         tempo_ff <= '0; tseen_ff <= '0; evcnt_ff <= '0; done_ff <= 1'b0;
         pend_ff <= 1'b0; out_v_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; consumed_ff <= consumed_in; ticks_ff <= ticks_in;
         len_ff <= len_in; skip_ff <= skip_in; run_ff <= run_in; cur_ff <= cur_in;
         meta_ff <= meta_in; held_ff <= held_in; tempo_ff <= tempo_in;
         tseen_ff <= tseen_in; evcnt_ff <= evcnt_in; done_ff <= done_in;
         pend_ff <= pend_in; out_v_ff <= out_v_in;
      end
      pend_cmd_ff <= pend_cmd_in;
      out_cmd_ff <= out_cmd_in;
   end

   a_pend_needs_out: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> out_v_ff) else $error("pending command without head command");
   a_pend_is_finish: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> pend_cmd_ff.kind == mtep_pkg::KIND_FINISH)
      else $error("second command is not a finish");
   a_done_no_take: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !restart) |=> done_ff) else $error("finished flag dropped");

endmodule

FILE: design/mtep_queue.sv
// Two-entry command queue between front parser and back end.
// Depends on mtep_pkg.
module mtep_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  mtep_pkg::cmd_type wr_cmd,
   output logic              rd_valid,
   input  logic              rd_ready,
   output mtep_pkg::cmd_type rd_cmd
);

   mtep_pkg::cmd_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_cmd   = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) mem_ff[wp_ff] <= wr_cmd;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue count out of range");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff) else $error("queue pointers");
   a_one_ptr: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd1 |-> wp_ff != rp_ff) else $error("queue pointers");

endmodule

FILE: design/mtep_back.sv
// Back end: tick scaling and tempo division by a shared restoring divider.
// Depends on mtep_pkg.
module mtep_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       src_tpq,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  mtep_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [27:0]       rsp_step,
   output logic [7:0]        rsp_sub_tick,
   output logic [7:0]        rsp_status_byte,
   output logic [7:0]        rsp_first_data,
   output logic [7:0]        rsp_second_data,
   output logic [15:0]       rsp_tempo_bpm,
   output logic [12:0]       rsp_events_in_chunk,
   output logic              rsp_last
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_POST = 4'b0100,
      S_OUT  = 4'b1000
   } bstate_type;

   bstate_type st_ff, st_in;
   mtep_pkg::cmd_type c_ff;
   logic [38:0] num_ff;     // dividend shifting out, quotient shifting in
   logic [23:0] den_ff;
   logic [24:0] rem_ff;
   logic [5:0]  it_ff;
   logic [31:0] ai_ff;
   logic [24:0] diff;
   logic [24:0] rsh;

   assign cmd_ready = st_ff == S_IDLE;
   assign rsp_valid = st_ff == S_OUT;
   assign rsh  = {rem_ff[23:0], num_ff[38]};
   assign diff = rsh - {1'b0, den_ff};

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE:  if (cmd_valid) st_in = (cmd.kind == mtep_pkg::KIND_FINISH) ? S_OUT : S_DIV;
         S_DIV:   if (it_ff == 6'd0) st_in = S_POST;
         S_POST:  st_in = S_OUT;
         S_OUT:   if (rsp_ready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_IDLE;
      else st_ff <= st_in;
      case (st_ff)
         S_IDLE: begin
            c_ff <= cmd;
            rem_ff <= '0;
            it_ff <= 6'd38;
            if (cmd.kind == mtep_pkg::KIND_TEMPO) begin
               num_ff <= {13'd0, mtep_pkg::US_PER_MINUTE} << 13;
               den_ff <= cmd.tempo_us;
               it_ff  <= 6'd25;
            end else begin
               // ticks * 96 needs at most 39 bits
               num_ff <= {7'd0, cmd.ticks} * 39'(mtep_pkg::TARGET_TPQ);
               den_ff <= {8'd0, (src_tpq == 16'd0) ? 16'd1 : src_tpq};
            end
         end
         S_DIV: begin
            it_ff <= it_ff - 6'd1;
            if (!diff[24]) begin
               rem_ff <= diff;
               num_ff <= {num_ff[37:0], 1'b1};
            end else begin
               rem_ff <= rsh;
               num_ff <= {num_ff[37:0], 1'b0};
            end
         end
         S_POST: ai_ff <= num_ff[31:0];
         default: ;
      endcase
   end

   // step and sub-step offset from the registered scaled tick count
   logic [4:0]  mod24;
   logic [27:0] q24;
   logic [7:0]  m8;
   logic [7:0]  frac_w;
   assign q24   = 28'((64'(ai_ff) * 64'd2863311531) >> 36);
   assign mod24 = 5'(ai_ff - 32'(q24) * 32'd24);
   assign m8    = {3'd0, mod24};
   // r * 255 / 24 = 10r + floor(5r / 8)
   assign frac_w = m8 * 8'd10 + ((m8 * 8'd5) >> 3);

   always_comb begin
      rsp_kind = c_ff.kind; rsp_last = c_ff.last;
      rsp_step = '0; rsp_sub_tick = '0; rsp_status_byte = '0;
      rsp_first_data = '0; rsp_second_data = '0; rsp_tempo_bpm = '0;
      rsp_events_in_chunk = '0;
      case (c_ff.kind)
         mtep_pkg::KIND_VOICE: begin
            rsp_step = q24;
            rsp_sub_tick = frac_w;
            rsp_status_byte = c_ff.status;
            rsp_first_data = c_ff.data1;
            rsp_second_data = c_ff.data2;
         end
         mtep_pkg::KIND_TEMPO: rsp_tempo_bpm = num_ff[15:0];
         mtep_pkg::KIND_FINISH: rsp_events_in_chunk = c_ff.count;
         default: ;
      endcase
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_POST |-> $past(st_ff) == S_DIV) else $error("post without divide");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_IDLE |-> !cmd_ready) else $error("accepting while busy");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for midi_track_event_parser: random and directed track bytes.
// Depends on mtep_pkg and the midi_track_event_parser RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // one response as the DUT presents it
   typedef struct {
      logic [1:0]  kind;
      logic [27:0] step;
      logic [7:0]  sub_tick;
      logic [7:0]  status_byte;
      logic [7:0]  first_data;
      logic [7:0]  second_data;
      logic [15:0] tempo_bpm;
      logic [12:0] events_in_chunk;
      logic        last;
   } midi_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = mtep_pkg::CSR_CHUNK_LENGTH;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [27:0] rsp_step;
   logic [7:0]  rsp_sub_tick;
   logic [7:0]  rsp_status_byte;
   logic [7:0]  rsp_first_data;
   logic [7:0]  rsp_second_data;
   logic [15:0] rsp_tempo_bpm;
   logic [12:0] rsp_events_in_chunk;
   logic        rsp_last;

   midi_track_event_parser dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Parser model state (mirrors the DUT's architectural state)
   // ---------------------------------------------------------------
   logic [31:0] cfg_chunk_len;
   logic [15:0] cfg_ppqn;
   logic [12:0] cfg_capacity;

   mtep_pkg::phase_type phase;
   logic [31:0] bytes_seen;
   logic [31:0] abs_ticks;
   logic [31:0] len_acc;
   logic [31:0] skip_left;
   logic [7:0]  run_status;
   logic [7:0]  cur_status;
   logic [7:0]  meta_type;
   logic [7:0]  held_byte;
   logic [23:0] tempo_acc;
   logic [1:0]  tempo_cnt;
   logic [12:0] voice_count;
   logic        parse_done;

   midi_result_type byte_results[$];   // results of the byte under evaluation
   midi_result_type expected_q[$];     // results still owed by the DUT
   logic [7:0]   pending_bytes[$];  // stimulus not yet presented
   logic [7:0]   track[$];          // chunk body under construction
   bit           failed = 1'b0;
   bit           quiet = 1'b0;      // no idling on either side
   bit           req_taken = 1'b0;
   int           req_gap = 0;
   int           rsp_stall = 0;

   function automatic void restart_parse();
      phase = mtep_pkg::PH_DELTA;
      bytes_seen = '0;
      abs_ticks = '0;
      len_acc = '0;
      skip_left = '0;
      run_status = '0;
      cur_status = '0;
      meta_type = '0;
      held_byte = '0;
      tempo_acc = '0;
      tempo_cnt = '0;
      voice_count = '0;
      parse_done = 1'b0;
   endfunction

   function automatic midi_result_type blank_result(logic [1:0] k);
      midi_result_type r;
      r = '{kind: k, step: '0, sub_tick: '0, status_byte: '0, first_data: '0,
            second_data: '0, tempo_bpm: '0, events_in_chunk: '0, last: 1'b0};
      return r;
   endfunction

   function automatic void push_finish();
      midi_result_type r;
      r = blank_result(mtep_pkg::KIND_FINISH);
      r.events_in_chunk = voice_count;
      parse_done = 1'b1;
      byte_results.push_back(r);
   endfunction

   function automatic bit stop_now();
      logic [12:0] cap;
      cap = (cfg_capacity > 13'd4096) ? 13'd4096 : cfg_capacity;
      return (bytes_seen >= cfg_chunk_len) || (voice_count >= cap);
   endfunction

   // rescale file ticks to 96 ppqn, split into step and sub-step offset
   function automatic void push_voice(logic [7:0] d2);
      logic [63:0] scaled;
      logic [31:0] internal_ticks;
      logic [31:0] frac;
      midi_result_type r;
      scaled = {32'd0, abs_ticks} * 64'd96;
      scaled = scaled / ((cfg_ppqn == 16'd0) ? 64'd1 : {48'd0, cfg_ppqn});
      internal_ticks = scaled[31:0];
      frac = ((internal_ticks % 32'd24) * 32'd255) / 32'd24;
      r = blank_result(mtep_pkg::KIND_VOICE);
      r.step = 28'(internal_ticks / 32'd24);
      r.sub_tick = frac[7:0];
      r.status_byte = cur_status;
      r.first_data = held_byte;
      r.second_data = d2;
      byte_results.push_back(r);
      voice_count = voice_count + 13'd1;
      phase = mtep_pkg::PH_DELTA;
   endfunction

   function automatic void begin_skip(logic [31:0] n);
      skip_left = n;
      phase = (n != 0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      bit again;
      bit is_data;
      midi_result_type r;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (phase)
            mtep_pkg::PH_DELTA, mtep_pkg::PH_DELTA_MORE: begin
               if (phase == mtep_pkg::PH_DELTA) len_acc = '0;
               len_acc = {len_acc[24:0], b[6:0]};
               if (b[7]) begin
                  phase = mtep_pkg::PH_DELTA_MORE;
               end else begin
                  abs_ticks = abs_ticks + len_acc;
                  phase = mtep_pkg::PH_STATUS;
               end
            end
            mtep_pkg::PH_STATUS: begin
               is_data = (b < mtep_pkg::ST_VOICE_LO);
               if (is_data) begin
                  cur_status = run_status;
               end else begin
                  run_status = b;
                  cur_status = b;
               end
               len_acc = '0;
               if (cur_status == mtep_pkg::ST_META) begin
                  phase = mtep_pkg::PH_META_TYPE;
               end else if (cur_status == mtep_pkg::ST_SYSEX ||
                            cur_status == mtep_pkg::ST_ESCAPE) begin
                  phase = mtep_pkg::PH_SYSEX_LEN;
               end else if (cur_status >= mtep_pkg::ST_VOICE_LO &&
                            cur_status < mtep_pkg::ST_SYSEX) begin
                  phase = mtep_pkg::PH_DATA1;
               end else begin
                  push_finish();
                  return;
               end
               // a data byte here doubles as the first byte after the status
               again = is_data;
            end
            mtep_pkg::PH_META_TYPE: begin
               meta_type = b;
               len_acc = '0;
               phase = mtep_pkg::PH_META_LEN;
            end
            mtep_pkg::PH_META_LEN: begin
               len_acc = {len_acc[24:0], b[6:0]};
               if (!b[7]) begin
                  if (meta_type == mtep_pkg::META_TEMPO && len_acc == 32'd3) begin
                     tempo_acc = '0;
                     tempo_cnt = '0;
                     phase = mtep_pkg::PH_TEMPO;
                  end else begin
                     begin_skip(len_acc);
                  end
               end
            end
            mtep_pkg::PH_TEMPO: begin
               tempo_acc = {tempo_acc[15:0], b};
               tempo_cnt = tempo_cnt + 2'd1;
               if (tempo_cnt == 2'd3) begin
                  tempo_cnt = '0;
                  phase = mtep_pkg::PH_DELTA;
                  if (tempo_acc != 0) begin
                     r = blank_result(mtep_pkg::KIND_TEMPO);
                     r.tempo_bpm = 16'(32'd60000000 / {8'd0, tempo_acc});
                     byte_results.push_back(r);
                  end
               end
            end
            mtep_pkg::PH_SYSEX_LEN: begin
               len_acc = {len_acc[24:0], b[6:0]};
               if (!b[7]) begin_skip(len_acc);
            end
            mtep_pkg::PH_SKIP: begin
               if (skip_left != 0) skip_left = skip_left - 32'd1;
               if (skip_left == 0) phase = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_DATA1: begin
               held_byte = b;
               if ((cur_status & mtep_pkg::ONE_DATA_MASK) == mtep_pkg::ONE_DATA_VAL) begin
                  push_voice(8'd0);
               end else begin
                  phase = mtep_pkg::PH_DATA2;
               end
            end
            mtep_pkg::PH_DATA2: begin
               push_voice(b);
            end
            default: begin
               phase = mtep_pkg::PH_DELTA;
            end
         endcase
      end
   endfunction

   // expected results for one accepted request byte
   function automatic void predict_request(logic [7:0] b);
      byte_results.delete();
      if (parse_done) return;
      if (phase == mtep_pkg::PH_DELTA && stop_now()) begin
         push_finish();
      end else begin
         if (bytes_seen != 32'hFFFF_FFFF) bytes_seen = bytes_seen + 32'd1;
         parse_byte(b);
         if (!parse_done && phase == mtep_pkg::PH_DELTA && stop_now()) push_finish();
      end
      if (byte_results.size() > 0) byte_results[$].last = 1'b1;
      foreach (byte_results[i]) expected_q.push_back(byte_results[i]);
   endfunction

   function automatic void apply_csr(logic [1:0] idx, logic [31:0] val);
      case (idx)
         mtep_pkg::CSR_CHUNK_LENGTH: begin
            cfg_chunk_len = val;
            restart_parse();
         end
         mtep_pkg::CSR_SRC_TPQ: cfg_ppqn = val[15:0];
         mtep_pkg::CSR_EVENT_CAP: cfg_capacity = val[12:0];
         default: ;
      endcase
   endfunction

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------
   // Monitor: everything sampled at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      midi_result_type want;
      if (!reset) begin
         if (csr_write_enable) apply_csr(csr_index, csr_write_data);
         if (req_valid && req_ready) begin
            predict_request(req_data_byte);
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response kind %0h", $time, rsp_kind);
               failed = 1'b1;
            end else begin
               want = expected_q.pop_front();
               report_field("kind", want.kind, rsp_kind);
               report_field("step", want.step, rsp_step);
               report_field("sub_tick", want.sub_tick, rsp_sub_tick);
               report_field("status_byte", want.status_byte, rsp_status_byte);
               report_field("first_data", want.first_data, rsp_first_data);
               report_field("second_data", want.second_data, rsp_second_data);
               report_field("tempo_bpm", want.tempo_bpm, rsp_tempo_bpm);
               report_field("events_in_chunk", want.events_in_chunk, rsp_events_in_chunk);
               report_field("last", want.last, rsp_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Request driver: bursts of idle cycles between requests
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the byte until accepted
      end else if (req_gap > 0) begin
         req_gap--;
         req_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
         req_valid <= 1'b1;
         req_data_byte <= pending_bytes.pop_front();
         if (!quiet && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 17);
      end else begin
         req_valid <= 1'b0;
      end
      req_taken = 1'b0;
   end

   // response back-pressure, also in bursts
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) rsp_stall = $urandom_range(1, 17);
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // idle: all requests in, all responses out, plus the divider's latency
   task automatic wait_idle();
      while (pending_bytes.size() > 0 || req_valid || expected_q.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // variable-length quantity, most significant group first
   task automatic put_vlq(logic [31:0] v);
      logic [7:0] grp[$];
      grp.push_front({1'b0, v[6:0]});
      v = v >> 7;
      while (v != 0) begin
         grp.push_front({1'b1, v[6:0]});
         v = v >> 7;
      end
      foreach (grp[i]) track.push_back(grp[i]);
   endtask

   task automatic put_bytes(int n);
      repeat (n) track.push_back(8'($urandom_range(0, 255)));
   endtask

   // one random, mostly well-formed event with its delta time
   task automatic put_event(inout logic [7:0] running);
      int pick;
      logic [7:0] st;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0: put_vlq($urandom());
         1, 2: put_vlq($urandom_range(128, 1 << 21));
         default: put_vlq($urandom_range(0, 127));
      endcase
      if (pick < 55) begin
         st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom())};
         if (!(running >= mtep_pkg::ST_VOICE_LO && running < mtep_pkg::ST_SYSEX &&
               $urandom_range(0, 2) == 0)) begin
            track.push_back(st);
            running = st;
         end
         track.push_back(8'($urandom_range(0, 127)));
         if ((running & mtep_pkg::ONE_DATA_MASK) != mtep_pkg::ONE_DATA_VAL)
            track.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom())
                                                        : 8'($urandom_range(0, 127)));
      end else if (pick < 68) begin
         track.push_back(mtep_pkg::ST_META);
         track.push_back(mtep_pkg::META_TEMPO);
         track.push_back(8'd3);
         if ($urandom_range(0, 7) == 0) begin
            track.push_back(8'd0);
            track.push_back(8'd0);
            track.push_back(8'($urandom_range(0, 1)));
         end else begin
            put_bytes(3);
         end
         running = mtep_pkg::ST_META;
      end else if (pick < 80) begin
         track.push_back(mtep_pkg::ST_META);
         track.push_back(($urandom_range(0, 3) == 0) ? mtep_pkg::META_TEMPO : 8'($urandom()));
         pick = $urandom_range(0, 6);
         if (pick == 3) pick = 4;
         if ($urandom_range(0, 3) == 0) track.push_back(8'h80);
         track.push_back(8'(pick));
         put_bytes(pick);
         running = mtep_pkg::ST_META;
      end else if (pick < 91) begin
         st = $urandom_range(0, 1) ? mtep_pkg::ST_SYSEX : mtep_pkg::ST_ESCAPE;
         track.push_back(st);
         pick = $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0) track.push_back(8'h80);
         track.push_back(8'(pick));
         put_bytes(pick);
         running = st;
      end else if (pick < 96) begin
         // raw byte in status position: running status on data, or anything
         st = 8'($urandom());
         track.push_back(st);
         if (st >= mtep_pkg::ST_VOICE_LO) running = st;
         put_bytes($urandom_range(0, 3));
      end else begin
         st = $urandom_range(0, 1) ? 8'($urandom_range(8'hF1, 8'hF6))
                                   : 8'($urandom_range(8'hF8, 8'hFE));
         track.push_back(st);
      end
   endtask

   // program the block while idle, then queue the track bytes
   task automatic run_chunk(logic [15:0] ppqn, logic [12:0] cap, logic [31:0] len);
      wait_idle();
      csr_write(mtep_pkg::CSR_SRC_TPQ, {16'd0, ppqn});
      csr_write(mtep_pkg::CSR_EVENT_CAP, {19'd0, cap});
      csr_write(mtep_pkg::CSR_CHUNK_LENGTH, len);   // restarts parsing, so written last
      foreach (track[i]) pending_bytes.push_back(track[i]);
      track.delete();
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      logic [7:0]  running;
      logic [15:0] ppqn;
      logic [12:0] cap;
      logic [31:0] len;
      int          n;

      cfg_chunk_len = '0;
      cfg_ppqn = 16'd96;
      cfg_capacity = '0;
      restart_parse();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // note on, running-status note, program change, pressure, tempo 120,
      // zero tempo, text meta, sysex, escape, longest delta with high data bytes
      track = {8'h00, 8'h90, 8'h3C, 8'h64, 8'h00, 8'h3C, 8'h00,
               8'h81, 8'h00, 8'hC0, 8'h05, 8'h00, 8'hD0, 8'h7F,
               8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20,
               8'h00, 8'hFF, 8'h51, 8'h03, 8'h00, 8'h00, 8'h00,
               8'h00, 8'hFF, 8'h01, 8'h02, 8'h41, 8'h42,
               8'h00, 8'hF0, 8'h02, 8'h01, 8'hF7, 8'h00, 8'hF7, 8'h00,
               8'h8F, 8'hFF, 8'hFF, 8'h7F, 8'hE0, 8'hFF, 8'hFF, 8'h00};
      run_chunk(16'd96, 13'd4096, 32'd49);
      // undefined status ends the chunk
      track = {8'h00, 8'h90, 8'h01, 8'h02, 8'h00, 8'hF4, 8'h00};
      run_chunk(16'd0, 13'd8191, 32'hFFFF_FFFF);
      // data byte with no running status yet
      track = {8'h05, 8'h40, 8'h00};
      run_chunk(16'd65535, 13'd10, 32'd3);
      // capacity of one, then capacity zero, then empty chunk
      track = {8'h7F, 8'hA0, 8'h11, 8'h22, 8'h00, 8'h90, 8'h01, 8'h02};
      run_chunk(16'd1, 13'd1, 32'd8);
      track = {8'h00, 8'h90};
      run_chunk(16'd96, 13'd0, 32'd100);
      track = {8'h00};
      run_chunk(16'd480, 13'd4096, 32'd0);

      // random tracks, mostly well formed
      for (int chunk = 0; chunk < 20; chunk++) begin
         running = '0;
         repeat ($urandom_range(4, 12)) put_event(running);
         n = track.size();
         case ($urandom_range(0, 9))
            0: len = 32'hFFFF_FFFF;
            1: len = $urandom_range(0, n);
            2: len = n + $urandom_range(1, 5);
            default: len = n;
         endcase
         case ($urandom_range(0, 7))
            0: ppqn = 16'd0;
            1: ppqn = 16'd65535;
            2: ppqn = 16'($urandom());
            3: ppqn = 16'd1;
            default: ppqn = $urandom_range(0, 1) ? 16'd96 : 16'd480;
         endcase
         case ($urandom_range(0, 7))
            0: cap = 13'd8191;
            1: cap = $urandom_range(0, 4);
            2: cap = 13'($urandom());
            default: cap = 13'd4096;
         endcase
         if (chunk == 16) quiet = 1'b1;   // closing stretch without idling
         run_chunk(ppqn, cap, len);
      end

      wait_idle();
      if (!failed && expected_q.size() == 0) begin
         $display("midi_track_event_parser: match");
      end else begin
         $display("midi_track_event_parser: mismatch");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("midi_track_event_parser: mismatch");
      $finish;
   end

endmodule

FILE: midi_track_event_parser.f
design/mtep_pkg.sv
design/mtep_front.sv
design/mtep_queue.sv
design/mtep_back.sv
design/midi_track_event_parser.sv
tb/sv/testbench.sv
